// File: rtl/pc_pkg.sv
// Package for the peak compressor: configuration record, register indexes,
// fixed-point constants and the exp2 root table. No dependencies.
package pc_pkg;

   localparam int LOG_FRAC_BITS = 24;
   localparam int EXP_STEPS     = 24;
   localparam int EXP_MAX_SHIFT = 40;

   localparam logic [23:0] ONE_Q23 = 24'd8388608;

   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_SLOPE     = 3'd1;
   localparam logic [2:0] CSR_ATTACK    = 3'd2;
   localparam logic [2:0] CSR_RELEASE   = 3'd3;
   localparam logic [2:0] CSR_MAKEUP    = 3'd4;
   localparam logic [2:0] CSR_ENABLE    = 3'd5;

   typedef struct packed {
      logic [23:0]        threshold_level;
      logic signed [16:0] gain_slope;
      logic [23:0]        attack_coef;
      logic [23:0]        release_coef;
      logic [19:0]        makeup_gain;
      logic               stage_enable;
   } cfg_type;

   typedef logic [30:0] exp_root_type [EXP_STEPS];

   // Successive square roots of 0.5 in Q0.31, each a truncated integer root.
   function automatic exp_root_type exp_root_table();
      exp_root_type tbl;
      logic [63:0]  c;
      logic [63:0]  v;
      logic [63:0]  res;
      logic [63:0]  bt;
      c = 64'd1 << 30;
      for (int i = 0; i < EXP_STEPS; i++) begin
         v   = c << 31;
         res = 64'd0;
         bt  = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (bt > v) bt = bt >> 2;
         end
         for (int j = 0; j < 32; j++) begin
            if (bt != 64'd0) begin
               if (v >= res + bt) begin
                  v   = v - (res + bt);
                  res = (res >> 1) + bt;
               end else begin
                  res = res >> 1;
               end
               bt = bt >> 2;
            end
         end
         c      = res;
         tbl[i] = c[30:0];
      end
      return tbl;
   endfunction

   localparam exp_root_type EXP_ROOT = exp_root_table();

endpackage

// File: rtl/peak_compressor_top.sv
// Top level of the peak compressor: stream ports, configuration registers
// and the sequenced core. Depends on pc_pkg and pc_core.
//
// Feed-forward peak compressor for signed Q4.23 audio samples. Each item
// carries one sample and two flags; each item yields exactly one result item
// holding the processed sample, the peak input meter and the least gain
// meter. The block works on one item at a time: req_tready is high only
// while the core is idle, and the next item is taken once the result has
// been handed off. All multiplications go through one shared multiplier
// under a sequencer. A sample with stage_enable low passes unchanged; an
// enabled sample runs the envelope update and the makeup and output
// multiplies. On the first sample of a block and every CONTROL_INTERVAL-th
// sample after it the gain is recomputed, which can add two log2
// evaluations (a normalizing shift plus 24 squaring steps each), an
// exponent multiply and 24 exp2 product steps. The user is to write the
// configuration registers through the csr_ port only while the block is
// idle, which the block does not enforce; they are not readable.
module peak_compressor_top #(
   parameter int SAMPLE_BITS      = 28,
   parameter int CONTROL_INTERVAL = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input items.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: in_sample, zero filled to whole bytes.
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: block_start (bit 0), clear_meters (bit 1).
   input  logic [1:0]             req_tuser,
   // Result items.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: out_sample, peak_input, least_gain, zero filled to whole bytes.
   output logic [((2*SAMPLE_BITS+24+7)/8)*8-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [2:0]             csr_addr,
   input  logic [23:0]            csr_wdata
);
   import pc_pkg::*;

   localparam int RSP_BITS = 2*SAMPLE_BITS + 24;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   cfg_type cfg_ff;

   logic [SAMPLE_BITS-1:0] out_sample;
   logic [SAMPLE_BITS-1:0] out_peak;
   logic [23:0]            out_gain;

   // Register file; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= 24'd1329505;
         cfg_ff.gain_slope      <= -17'sd46811;
         cfg_ff.attack_coef     <= 24'd16761329;
         cfg_ff.release_coef    <= 24'd16776051;
         cfg_ff.makeup_gain     <= 20'd130762;
         cfg_ff.stage_enable    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD: cfg_ff.threshold_level <= csr_wdata;
            CSR_SLOPE:     cfg_ff.gain_slope      <= csr_wdata[16:0];
            CSR_ATTACK:    cfg_ff.attack_coef     <= csr_wdata;
            CSR_RELEASE:   cfg_ff.release_coef    <= csr_wdata;
            CSR_MAKEUP:    cfg_ff.makeup_gain     <= csr_wdata[19:0];
            CSR_ENABLE:    cfg_ff.stage_enable    <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   pc_core #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .CONTROL_INTERVAL (CONTROL_INTERVAL)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_sample      (req_tdata[SAMPLE_BITS-1:0]),
      .in_block_start (req_tuser[0]),
      .in_clear       (req_tuser[1]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_sample     (out_sample),
      .out_peak       (out_peak),
      .out_gain       (out_gain)
   );

   assign rsp_tdata = RSP_W'({out_gain, out_peak, out_sample});

endmodule

// File: rtl/pc_core.sv
// Sequencer and datapath of the peak compressor around one shared multiplier.
// Depends on pc_pkg.
module pc_core #(
   parameter int SAMPLE_BITS      = 28,
   parameter int CONTROL_INTERVAL = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pc_pkg::cfg_type        cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic                   in_block_start,
   input  logic                   in_clear,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_sample,
   output logic [SAMPLE_BITS-1:0] out_peak,
   output logic [23:0]            out_gain
);
   import pc_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int W  = SB + 4;
   localparam int NW = (W > 32) ? W : 32;
   localparam int NB = $clog2(NW);
   localparam int LW = NB + LOG_FRAC_BITS;
   localparam int PB = NW + 32;
   localparam int SW = PB + 1;
   localparam int CW = (W > 28) ? W : 28;
   localparam int PW = (CONTROL_INTERVAL > 1) ? $clog2(CONTROL_INTERVAL) : 1;
   localparam int YW = SB + 6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENV1, ST_ENV2, ST_CHECK, ST_NORM, ST_SQ, ST_DIFF,
      ST_MULE, ST_EXP, ST_SHIFT, ST_GM, ST_Y, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [SB-1:0]    mag_ff, res_ff, peak_ff;
   logic             neg_ff, bs_ff, clr_ff, sel_ff;
   logic [W-1:0]     env_ff;
   logic [W+23:0]    acc_ff;
   logic [23:0]      gain_ff, gmeter_ff, frac_ff, e_ff;
   logic [PW-1:0]    phase_ff;
   logic [NW-1:0]    norm_ff;
   logic [NB-1:0]    n_ff;
   logic [31:0]      m_ff, r_ff;
   logic [4:0]       cnt_ff;
   logic [LW-1:0]    le_ff, diff_ff;
   logic [6:0]       k_ff;
   logic [27:0]      gm_ff;

   logic [NW-1:0]    mul_a;
   logic [31:0]      mul_b;
   logic [PB-1:0]    prod;

   logic [W-1:0]     a4;
   logic [23:0]      pole;
   logic [24:0]      pole_c;
   logic [16:0]      slope_mag;
   logic [SW-1:0]    env_sum;
   logic [27:0]      thr;
   logic [CW-1:0]    thr_eff;
   logic [32:0]      sq;
   logic [23:0]      frac_next;
   logic [LW-1:0]    lt;
   logic [30:0]      e_full;
   logic [6:0]       sh_amt;
   logic [23:0]      gain_exp;
   logic [44:0]      gm_sum;
   logic [SB+28:0]   y_sum;
   logic [YW-1:0]    y_val;
   logic [YW-1:0]    y_lim_n, y_lim_p;
   logic [SB-1:0]    y_res;
   logic [PW-1:0]    ph_eff;
   logic [SB-1:0]    in_mag;

   assign a4        = {mag_ff, 4'b0000};
   assign pole      = (a4 > env_ff) ? cfg.attack_coef : cfg.release_coef;
   assign pole_c    = 25'h100_0000 - {1'b0, pole};
   assign slope_mag = 17'd0 - cfg.gain_slope;
   assign thr       = {cfg.threshold_level, 4'b0000};
   assign thr_eff   = (thr == 28'd0) ? CW'(1) : CW'(thr);
   assign lt        = {n_ff, frac_ff};
   assign ph_eff    = bs_ff ? '0 : phase_ff;
   assign in_mag    = in_sample[SB-1] ? (SB'(0) - in_sample) : in_sample;

   // One multiplier, its operands picked by the sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ENV1: begin mul_a = NW'(env_ff);  mul_b = 32'(pole);   end
         ST_ENV2: begin mul_a = NW'(a4);      mul_b = 32'(pole_c); end
         ST_SQ:   begin mul_a = NW'(m_ff);    mul_b = m_ff;        end
         ST_MULE: begin mul_a = NW'(diff_ff); mul_b = 32'(slope_mag); end
         ST_EXP:  begin mul_a = NW'(r_ff);    mul_b = 32'(EXP_ROOT[cnt_ff]); end
         ST_GM:   begin mul_a = NW'(gain_ff); mul_b = 32'(cfg.makeup_gain); end
         ST_Y:    begin mul_a = NW'(mag_ff);  mul_b = 32'(gm_ff);  end
         default: begin mul_a = '0;           mul_b = '0;          end
      endcase
   end

   assign prod = PB'(mul_a) * PB'(mul_b);

   always_comb begin
      env_sum   = SW'(acc_ff) + SW'(prod) + SW'(1 << 23);
      sq        = prod[63:31];
      frac_next = frac_ff | (sq[32] ? (24'd1 << cnt_ff) : 24'd0);
      e_full    = prod[46:16];
      sh_amt    = 7'd8 + k_ff;
      gain_exp  = 24'(r_ff >> sh_amt);
      gm_sum    = 45'(prod) + 45'd32768;
      y_sum     = (SB+29)'(prod) + (SB+29)'(1 << 22);
      y_val     = y_sum[23 +: YW];
      y_lim_n   = YW'(1) << (SB - 1);
      y_lim_p   = y_lim_n - YW'(1);
      if (neg_ff) begin
         y_res = SB'(YW'(0) - ((y_val > y_lim_n) ? y_lim_n : y_val));
      end else begin
         y_res = SB'((y_val > y_lim_p) ? y_lim_p : y_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         env_ff    <= '0;
         gain_ff   <= ONE_Q23;
         phase_ff  <= '0;
         peak_ff   <= '0;
         gmeter_ff <= ONE_Q23;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  mag_ff <= in_mag;
                  neg_ff <= in_sample[SB-1];
                  bs_ff  <= in_block_start;
                  clr_ff <= in_clear;
                  if (cfg.stage_enable) begin
                     if (in_mag > peak_ff) peak_ff <= in_mag;
                     state_ff <= ST_ENV1;
                  end else begin
                     res_ff   <= in_sample;
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_ENV1: begin
               acc_ff   <= prod[W+23:0];
               state_ff <= ST_ENV2;
            end
            ST_ENV2: begin
               env_ff   <= env_sum[24 +: W];
               phase_ff <= (ph_eff == PW'(CONTROL_INTERVAL - 1)) ? '0 : ph_eff + PW'(1);
               state_ff <= (ph_eff == '0) ? ST_CHECK : ST_GM;
            end
            ST_CHECK: begin
               if ((CW'(env_ff) <= thr_eff) || !cfg.gain_slope[16]) begin
                  gain_ff <= ONE_Q23;
                  if (ONE_Q23 < gmeter_ff) gmeter_ff <= ONE_Q23;
                  state_ff <= ST_GM;
               end else begin
                  norm_ff  <= NW'(env_ff);
                  n_ff     <= NB'(NW - 1);
                  frac_ff  <= '0;
                  sel_ff   <= 1'b0;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (norm_ff[NW-1]) begin
                  m_ff     <= norm_ff[NW-1 -: 32];
                  cnt_ff   <= 5'd23;
                  state_ff <= ST_SQ;
               end else begin
                  norm_ff <= norm_ff << 1;
                  n_ff    <= n_ff - NB'(1);
               end
            end
            ST_SQ: begin
               m_ff   <= sq[32] ? sq[32:1] : sq[31:0];
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0 && !sel_ff) begin
                  // Envelope log done; start on the threshold.
                  le_ff    <= {n_ff, frac_next};
                  norm_ff  <= NW'(thr_eff);
                  n_ff     <= NB'(NW - 1);
                  frac_ff  <= '0;
                  sel_ff   <= 1'b1;
                  state_ff <= ST_NORM;
               end else begin
                  frac_ff <= frac_next;
                  if (cnt_ff == 5'd0) state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               if (le_ff <= lt) begin
                  gain_ff <= ONE_Q23;
                  if (ONE_Q23 < gmeter_ff) gmeter_ff <= ONE_Q23;
                  state_ff <= ST_GM;
               end else begin
                  diff_ff  <= le_ff - lt;
                  state_ff <= ST_MULE;
               end
            end
            ST_MULE: begin
               if (e_full[30:24] > 7'(EXP_MAX_SHIFT)) begin
                  gain_ff   <= '0;
                  gmeter_ff <= '0;
                  state_ff  <= ST_GM;
               end else begin
                  e_ff     <= e_full[23:0];
                  k_ff     <= e_full[30:24];
                  r_ff     <= 32'h8000_0000;
                  cnt_ff   <= '0;
                  state_ff <= ST_EXP;
               end
            end
            ST_EXP: begin
               if (e_ff[23]) r_ff <= prod[62:31];
               e_ff   <= e_ff << 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(EXP_STEPS - 1)) state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               gain_ff <= gain_exp;
               if (gain_exp < gmeter_ff) gmeter_ff <= gain_exp;
               state_ff <= ST_GM;
            end
            ST_GM: begin
               gm_ff    <= gm_sum[43:16];
               state_ff <= ST_Y;
            end
            ST_Y: begin
               res_ff   <= y_res;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_ready) begin
                  if (clr_ff) begin
                     peak_ff   <= '0;
                     gmeter_ff <= ONE_Q23;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = (state_ff == ST_OUT);
   assign out_sample = res_ff;
   assign out_peak   = peak_ff;
   assign out_gain   = gmeter_ff;

`ifndef SYNTHESIS
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= ONE_Q23 && gmeter_ff <= ONE_Q23)
      else $error("gain above unity");
   a_meter_tracks_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |=> gmeter_ff <= gain_ff)
      else $error("gain meter above the gain just computed");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PW'(CONTROL_INTERVAL - 1))
      else $error("control phase out of range");
   a_peak_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_OUT) |=> $stable(peak_ff))
      else $error("peak meter changed mid item");
`endif

endmodule

// File: tb/tb_peak_compressor_top.sv
// Self-checking testbench for peak_compressor_top: directed table, then random
// phases under several register settings, checked against a built-in model.
// Depends on pc_pkg and the peak_compressor_top RTL.
module tb_peak_compressor_top;
   import pc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 230;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [27:0] out_sample;
      logic [27:0] peak_input;
      logic [23:0] least_gain;
   } result_type;

   typedef struct {
      logic [27:0] sample;
      logic        block_start;
      logic        clear_meters;
      logic        typed;
      result_type  want;
   } sample_item_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      csr_index;
      logic [23:0]     csr_value;
      sample_item_type item;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   peak_compressor_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model copy of the registers and the processing state.
   logic [23:0] m_threshold;
   logic [16:0] m_slope;
   logic [23:0] m_attack;
   logic [23:0] m_release;
   logic [19:0] m_makeup;
   logic        m_enable;
   logic [63:0] m_envelope;
   logic [63:0] m_gain;
   logic [63:0] m_phase;
   logic [63:0] m_peak;
   logic [63:0] m_least;
   logic [63:0] half_roots [1:24];

   sample_item_type offered_items [$];
   result_type      pending_results [$];
   int              accepted_items = 0;
   int              mismatches = 0;
   int              idle_cycles = 0;
   bit              quiet = 0;
   bit              hold_request = 0;
   int              hold_left = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // log2 with 24 fraction bits by repeated squaring of the Q1.31 mantissa.
   function automatic logic [63:0] log2_fixed(logic [63:0] v);
      int n;
      logic [63:0] m;
      logic [63:0] r;
      n = 63;
      while (n > 0 && v[n] == 1'b0) n--;
      m = (n >= 31) ? (v >> (n - 31)) : (v << (31 - n));
      r = 64'(n) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] exp2_neg(logic [63:0] e);
      logic [63:0] k;
      logic [63:0] r;
      k = e >> 24;
      r = 64'd1 << 31;
      if (k > 40) return 0;
      for (int i = 1; i <= 24; i++) begin
         if (e[24 - i]) r = (r * half_roots[i]) >> 31;
      end
      return r >> (8 + k);
   endfunction

   function automatic logic [63:0] target_gain();
      logic [63:0] thr;
      logic [63:0] le;
      logic [63:0] lt;
      logic [63:0] depth;
      thr = 64'(m_threshold) << 4;
      if (thr == 0) thr = 1;        // a zero threshold acts as one envelope LSB
      if (m_envelope <= thr || !m_slope[16]) return 64'(ONE_Q23);
      le = log2_fixed(m_envelope);
      lt = log2_fixed(thr);
      if (le <= lt) return 64'(ONE_Q23);
      depth = 64'(18'h20000 - {1'b0, m_slope});
      return exp2_neg((depth * (le - lt)) >> 16);
   endfunction

   function automatic result_type compress_sample(sample_item_type it);
      result_type  res;
      logic [63:0] mag;
      logic [63:0] a4;
      logic [63:0] pole;
      logic [63:0] gm;
      logic [63:0] y;
      mag = it.sample[27] ? (64'd1 << 28) - 64'(it.sample) : 64'(it.sample);
      res.out_sample = it.sample;
      if (m_enable) begin
         a4 = mag << 4;
         pole = (a4 > m_envelope) ? 64'(m_attack) : 64'(m_release);
         if (mag > m_peak) m_peak = mag;
         m_envelope = (pole * m_envelope + ((64'd1 << 24) - pole) * a4 + (64'd1 << 23)) >> 24;
         if (it.block_start) m_phase = 0;
         if (m_phase == 0) begin
            m_gain = target_gain();
            if (m_gain < m_least) m_least = m_gain;
         end
         m_phase = (m_phase + 1 >= 8) ? 0 : m_phase + 1;
         gm = (m_gain * 64'(m_makeup) + 32768) >> 16;
         y = (mag * gm + 4194304) >> 23;
         if (it.sample[27]) begin
            if (y > (64'd1 << 27)) y = 64'd1 << 27;
            res.out_sample = 28'((64'd1 << 28) - y);
         end else begin
            if (y > (64'd1 << 27) - 1) y = (64'd1 << 27) - 1;
            res.out_sample = y[27:0];
         end
      end
      res.peak_input = m_peak[27:0];
      res.least_gain = m_least[23:0];
      if (it.clear_meters) begin
         m_peak = 0;
         m_least = 64'(ONE_Q23);
      end
      return res;
   endfunction

   // Result check first, since a result taken at this edge belongs to an older item.
   always @(posedge clock) begin
      result_type      got;
      result_type      want;
      sample_item_type it;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.out_sample = rsp_tdata[27:0];
            got.peak_input = rsp_tdata[55:28];
            got.least_gain = rsp_tdata[79:56];
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: out %h/%h peak %h/%h least %h/%h (want/got)",
                              want.out_sample, got.out_sample, want.peak_input,
                              got.peak_input, want.least_gain, got.least_gain);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            it = offered_items.pop_front();
            want = compress_sample(it);
            pending_results.push_back(it.typed ? it.want : want);
            accepted_items <= accepted_items + 1;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("peak_compressor_top test failed");
            $finish;
         end
      end
   end

   // Receiver: random stalls, a quiet mode, and one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 13);
      end
   end

   task automatic send_sample(sample_item_type it);
      int seen_count;
      if (!quiet && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      offered_items.push_back(it);
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, it.sample};
      req_tuser <= {it.clear_meters, it.block_start};
      seen_count = accepted_items;
      do @(negedge clock); while (accepted_items == seen_count);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 || offered_items.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [23:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_THRESHOLD: m_threshold = value;
         CSR_SLOPE:     m_slope = value[16:0];
         CSR_ATTACK:    m_attack = value;
         CSR_RELEASE:   m_release = value;
         CSR_MAKEUP:    m_makeup = value[19:0];
         CSR_ENABLE:    m_enable = value[0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type item_row(logic [27:0] s, logic st, logic cl);
      stim_row_type r;
      r.kind = ROW_ITEM;
      r.csr_index = '0;
      r.csr_value = '0;
      r.item = '{s, st, cl, 1'b0, '{'0, '0, '0}};
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [27:0] s, logic st, logic cl,
                                              logic [27:0] o, logic [27:0] p, logic [23:0] g);
      stim_row_type r;
      r = item_row(s, st, cl);
      r.item.typed = 1'b1;
      r.item.want = '{o, p, g};
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [2:0] index, logic [23:0] value);
      stim_row_type r;
      r = item_row('0, 1'b0, 1'b0);
      r.kind = ROW_CSR;
      r.csr_index = index;
      r.csr_value = value;
      return r;
   endfunction

   function automatic logic [27:0] random_sample();
      logic [27:0] mag;
      case ($urandom_range(2))
         0: return 28'($urandom());
         1: mag = 28'($urandom_range(1 << 22, (1 << 27) - 1));
         default: mag = 28'($urandom_range(0, 1 << 20));
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   initial begin
      stim_row_type    rows [$];
      sample_item_type it;
      logic [63:0]     c;

      c = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
         c = int_sqrt(c << 31);
         half_roots[i] = c;
      end
      m_threshold = 24'd1329505;
      m_slope = 17'd0 - 17'd46811;
      m_attack = 24'd16761329;
      m_release = 24'd16776051;
      m_makeup = 20'd130762;
      m_enable = 1'b1;
      m_envelope = 0;
      m_gain = 64'(ONE_Q23);
      m_phase = 0;
      m_peak = 0;
      m_least = 64'(ONE_Q23);

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Silence after reset leaves unity gain and empty meters.
      rows.push_back(typed_row(28'h0000000, 1, 0, 28'h0, 28'h0, ONE_Q23));
      rows.push_back(item_row(28'h7FFFFFF, 0, 0));
      rows.push_back(item_row(28'h8000000, 0, 0));
      rows.push_back(item_row(28'hFFFFFFF, 0, 0));
      rows.push_back(item_row(28'h0000001, 1, 0));
      rows.push_back(item_row(28'h7FFFFFF, 1, 0));
      rows.push_back(item_row(28'h7FFFFFF, 1, 0));
      rows.push_back(item_row(28'h4000000, 0, 1));
      // Bypass: samples pass unchanged and the cleared meters hold.
      rows.push_back(csr_row(CSR_ENABLE, 24'd0));
      rows.push_back(typed_row(28'h8000000, 0, 0, 28'h8000000, 28'h0, ONE_Q23));
      rows.push_back(typed_row(28'h7FFFFFF, 1, 1, 28'h7FFFFFF, 28'h0, ONE_Q23));
      rows.push_back(typed_row(28'h1234567, 0, 0, 28'h1234567, 28'h0, ONE_Q23));
      rows.push_back(csr_row(CSR_ENABLE, 24'd1));
      // Zero threshold with the largest makeup gain.
      rows.push_back(csr_row(CSR_THRESHOLD, 24'd0));
      rows.push_back(csr_row(CSR_MAKEUP, 24'd1038676));
      rows.push_back(item_row(28'h7FFFFFF, 1, 0));
      rows.push_back(item_row(28'h8000000, 0, 0));
      // A slope of zero never reduces gain.
      rows.push_back(csr_row(CSR_SLOPE, 24'd0));
      rows.push_back(item_row(28'h7FFFFFF, 1, 0));
      // Steepest slope with an instant attack pushes the gain toward zero.
      rows.push_back(csr_row(CSR_SLOPE, 24'h010000));
      rows.push_back(csr_row(CSR_ATTACK, 24'd0));
      rows.push_back(csr_row(CSR_RELEASE, 24'hFFFFFF));
      rows.push_back(item_row(28'h7FFFFFF, 1, 0));
      rows.push_back(item_row(28'h0000001, 0, 1));
      rows.push_back(csr_row(CSR_THRESHOLD, 24'd8388608));
      rows.push_back(csr_row(CSR_ATTACK, 24'hFFFFFF));
      rows.push_back(csr_row(CSR_MAKEUP, 24'd16450));
      rows.push_back(item_row(28'h7FFFFFF, 1, 1));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            drain();
            write_register(rows[i].csr_index, rows[i].csr_value);
         end else begin
            send_sample(rows[i].item);
         end
      end

      // Random phases; each starts from fresh register values, some at the limits.
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         quiet = (ph == 2);
         write_register(CSR_THRESHOLD, (ph == 3) ? 24'd8389 :
                        24'($urandom_range(8389, 8388608)));
         write_register(CSR_SLOPE, (ph == 4) ? 24'(-17'sd62259) :
                        24'(17'(-$urandom_range(0, 62259))));
         write_register(CSR_ATTACK, (ph == 5) ? 24'd0 : 24'($urandom()));
         write_register(CSR_RELEASE, (ph == 5) ? 24'hFFFFFF :
                        24'($urandom_range(14000000, 16777215)));
         write_register(CSR_MAKEUP, (ph == 6) ? 24'd1038676 :
                        24'($urandom_range(16450, 1038676)));
         write_register(CSR_ENABLE, (ph == 7) ? 24'd0 : 24'd1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 40) hold_request = 1;
            if (ph == 1 && n == 120) drain();
            it.sample = random_sample();
            it.block_start = (n % 32 == 0) || ($urandom_range(99) < 3);
            it.clear_meters = ($urandom_range(99) < 5);
            it.typed = 1'b0;
            it.want = '{'0, '0, '0};
            send_sample(it);
         end
      end

      drain();
      repeat (200) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("peak_compressor_top test passed");
      else
         $display("peak_compressor_top test failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/pc_pkg.sv
rtl/pc_core.sv
rtl/peak_compressor_top.sv
tb/tb_peak_compressor_top.sv
